// ----- rtl/btpm_pkg.sv -----
// Shared types, sizes and codes for the binary trie prefix match block.
package btpm_pkg;

    localparam int NODES    = 4096;
    localparam int NODE_W   = $clog2(NODES);
    localparam int KEY_BITS = 32;
    localparam int HOP_BITS = 16;
    localparam int LEN_W    = 6;
    localparam int CNT_W    = NODE_W + 1;
    localparam int PATH_D   = KEY_BITS + 1;

    typedef logic [1:0] t_op;
    localparam t_op OP_LOOKUP = 2'd0;
    localparam t_op OP_INSERT = 2'd1;
    localparam t_op OP_DELETE = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_DONE     = 2'd0;
    localparam t_status ST_NOTFOUND = 2'd1;
    localparam t_status ST_FULL     = 2'd2;

    typedef struct packed {
        logic [NODE_W-1:0]   left;
        logic [NODE_W-1:0]   right;
        logic                valid;
        logic [HOP_BITS-1:0] hop;
    } t_node;

    // Bit idx of the key counted from the most significant end.
    function automatic logic key_bit(input logic [KEY_BITS-1:0] key,
                                     input logic [LEN_W-1:0] idx);
        logic [LEN_W-1:0] pos;
        pos = LEN_W'(KEY_BITS - 1) - idx;
        return key[pos[$clog2(KEY_BITS)-1:0]];
    endfunction

endpackage

// ----- rtl/binary_trie_prefix_match.sv -----
// Binary trie longest-prefix-match table: lookup, insert and delete over a node RAM.
// Lookup reads one node per trie level visited, up to the full key length.
// Insert walks existing levels, then adds a new node per remaining level; delete
// frees each emptied node and makes a final check. One item is processed at a time.
// After reset a clearing pass initializes the node and free-list RAMs
// while busy stays high; results are one-cycle strobes the receiver cannot stall.
module binary_trie_prefix_match
    import btpm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_opcode,
    input  logic [KEY_BITS-1:0] i_key_bits,
    input  logic [LEN_W-1:0]    i_key_length,
    input  logic [HOP_BITS-1:0] i_next_hop,
    output logic                o_valid,
    output logic                o_hit,
    output logic [HOP_BITS-1:0] o_hop_out,
    output logic [1:0]          o_status
);
    localparam int PW = $clog2(PATH_D);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RD, S_DAT, S_FRD, S_FDAT, S_NEW, S_UCHK, S_UP, S_UPD
    } t_state;

    t_state r_state, n_state;
    t_op r_op, n_op;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [LEN_W-1:0] r_len, n_len, r_i, n_i;
    logic [HOP_BITS-1:0] r_hop, n_hop;
    logic [NODE_W-1:0] r_n, n_n, r_clr, n_clr;
    t_node r_nd, n_nd;
    logic [CNT_W-1:0] r_fc, n_fc;
    logic r_valid, n_valid, r_hit, n_hit;
    logic [HOP_BITS-1:0] r_hop_o, n_hop_o;
    t_status r_status, n_status;

    logic node_we;
    logic [NODE_W-1:0] node_waddr, node_raddr;
    t_node node_wdata, node_rdata;
    logic free_we;
    logic [NODE_W-1:0] free_waddr, free_wdata, free_raddr, free_rdata;
    logic path_we;
    logic [PW-1:0] path_waddr, path_raddr;
    logic [NODE_W-1:0] path_wdata, path_rdata;

    btpm_ram #(.WIDTH($bits(t_node)), .DEPTH(NODES)) u_node (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_waddr), .i_wdata(node_wdata),
        .i_raddr(node_raddr), .o_rdata(node_rdata)
    );
    btpm_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_free (
        .i_clk(i_clk), .i_we(free_we), .i_waddr(free_waddr), .i_wdata(free_wdata),
        .i_raddr(free_raddr), .o_rdata(free_rdata)
    );
    btpm_ram #(.WIDTH(NODE_W), .DEPTH(PATH_D)) u_path (
        .i_clk(i_clk), .i_we(path_we), .i_waddr(path_waddr), .i_wdata(path_wdata),
        .i_raddr(path_raddr), .o_rdata(path_rdata)
    );

    always_comb begin
        logic b;
        logic [NODE_W-1:0] c;
        logic [CNT_W-1:0] fcm1;
        t_node nd;
        n_state = r_state; n_op = r_op; n_key = r_key; n_len = r_len; n_i = r_i;
        n_hop = r_hop; n_n = r_n; n_clr = r_clr; n_nd = r_nd; n_fc = r_fc;
        n_valid = 1'b0; n_hit = r_hit; n_hop_o = r_hop_o; n_status = r_status;
        node_we = 1'b0; node_waddr = r_n; node_wdata = '0; node_raddr = r_n;
        free_we = 1'b0; free_waddr = r_fc[NODE_W-1:0]; free_wdata = r_n;
        fcm1 = r_fc - CNT_W'(1);
        free_raddr = fcm1[NODE_W-1:0];
        path_we = 1'b0; path_waddr = '0; path_wdata = '0;
        path_raddr = PW'(r_i - LEN_W'(1));
        b = key_bit(r_key, r_i);
        c = b ? node_rdata.right : node_rdata.left;
        nd = node_rdata;
        unique case (r_state)
            S_INIT: begin
                node_we = 1'b1; node_waddr = r_clr;
                free_we = 1'b1; free_waddr = r_clr; free_wdata = r_clr + NODE_W'(1);
                n_clr = r_clr + NODE_W'(1);
                if (r_clr == NODE_W'(NODES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_op = i_opcode; n_key = i_key_bits; n_hop = i_next_hop;
                    n_len = (i_key_length > LEN_W'(KEY_BITS)) ? LEN_W'(KEY_BITS)
                                                              : i_key_length;
                    n_n = '0; n_i = '0; n_hit = 1'b0; n_hop_o = '0; n_status = ST_DONE;
                    path_we = 1'b1;
                    if (i_opcode == OP_LOOKUP || i_opcode == OP_INSERT ||
                        i_opcode == OP_DELETE) begin
                        n_state = S_RD;
                    end else begin
                        n_valid = 1'b1;
                    end
                end
            end
            S_RD: n_state = S_DAT;
            S_DAT: begin
                case (r_op)
                    OP_LOOKUP: begin
                        if (node_rdata.valid) begin
                            n_hit = 1'b1; n_hop_o = node_rdata.hop;
                        end
                        if (r_i == r_len || c == '0) begin
                            n_valid = 1'b1; n_state = S_IDLE;
                        end else begin
                            n_n = c; n_i = r_i + LEN_W'(1); n_state = S_RD;
                        end
                    end
                    OP_INSERT: begin
                        if (r_i != r_len && c != '0) begin
                            n_n = c; n_i = r_i + LEN_W'(1); n_state = S_RD;
                        end else if (CNT_W'(r_len - r_i) > r_fc) begin
                            n_status = ST_FULL; n_valid = 1'b1; n_state = S_IDLE;
                        end else if (r_i == r_len) begin
                            nd.valid = 1'b1; nd.hop = r_hop;
                            node_we = 1'b1; node_wdata = nd;
                            n_valid = 1'b1; n_state = S_IDLE;
                        end else begin
                            n_nd = node_rdata; n_state = S_FRD;
                        end
                    end
                    default: begin
                        if (r_i == r_len) begin
                            if (!node_rdata.valid) begin
                                n_status = ST_NOTFOUND; n_valid = 1'b1; n_state = S_IDLE;
                            end else begin
                                nd.valid = 1'b0; nd.hop = '0;
                                node_we = 1'b1; node_wdata = nd;
                                n_nd = nd; n_state = S_UCHK;
                            end
                        end else if (c == '0) begin
                            n_status = ST_NOTFOUND; n_valid = 1'b1; n_state = S_IDLE;
                        end else begin
                            path_we = 1'b1; path_waddr = PW'(r_i + LEN_W'(1));
                            path_wdata = c;
                            n_n = c; n_i = r_i + LEN_W'(1); n_state = S_RD;
                        end
                    end
                endcase
            end
            S_FRD: n_state = S_FDAT;
            S_FDAT: begin
                nd = r_nd;
                if (b) nd.right = free_rdata; else nd.left = free_rdata;
                node_we = 1'b1; node_wdata = nd;
                n_n = free_rdata; n_nd = '0; n_state = S_NEW;
            end
            S_NEW: begin
                // The new node is cleared, or takes the hop when it ends the prefix.
                node_we = 1'b1;
                n_fc = fcm1; n_i = r_i + LEN_W'(1);
                if (r_i + LEN_W'(1) == r_len) begin
                    nd = '0; nd.valid = 1'b1; nd.hop = r_hop;
                    node_wdata = nd;
                    n_valid = 1'b1; n_state = S_IDLE;
                end else begin
                    n_state = S_FRD;
                end
            end
            S_UCHK: begin
                if (r_i == '0 || r_nd.valid || r_nd.left != '0 || r_nd.right != '0) begin
                    n_valid = 1'b1; n_state = S_IDLE;
                end else begin
                    node_we = 1'b1;
                    if (r_fc < CNT_W'(NODES)) begin
                        free_we = 1'b1; n_fc = r_fc + CNT_W'(1);
                    end
                    n_state = S_UP;
                end
            end
            S_UP: begin
                node_raddr = path_rdata; n_n = path_rdata; n_state = S_UPD;
            end
            S_UPD: begin
                if (key_bit(r_key, r_i - LEN_W'(1))) nd.right = '0; else nd.left = '0;
                node_we = 1'b1; node_wdata = nd;
                n_nd = nd; n_i = r_i - LEN_W'(1); n_state = S_UCHK;
            end
            default: n_state = S_IDLE;
        endcase
        if (n_valid && r_op != OP_LOOKUP) begin
            n_hit = 1'b0; n_hop_o = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT; r_clr <= '0; r_fc <= CNT_W'(NODES - 1);
            r_valid <= 1'b0; r_op <= OP_LOOKUP;
        end else begin
            r_state <= n_state; r_clr <= n_clr; r_fc <= n_fc;
            r_valid <= n_valid; r_op <= n_op;
        end
        r_key <= n_key; r_len <= n_len; r_i <= n_i; r_hop <= n_hop; r_n <= n_n;
        r_nd <= n_nd; r_hit <= n_hit; r_hop_o <= n_hop_o; r_status <= n_status;
    end

    assign busy      = (r_state != S_IDLE);
    assign o_valid   = r_valid;
    assign o_hit     = r_hit;
    assign o_hop_out = r_hop_o;
    assign o_status  = r_status;

    a_fc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc <= CNT_W'(NODES - 1)) else $error("free count out of range");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_hop_out == '0) else $error("hop without hit");
    a_status_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_DONE |-> !o_hit) else $error("hit with error status");
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");
endmodule

// ----- rtl/btpm_ram.sv -----
// Simple dual-port synchronous RAM with a registered read.
module btpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
